// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the timer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mcit_pkg.sv =====
// Package of the interval timer: field widths, command and status codes, shared types.
`timescale 1ns / 1ps
package mcit_pkg;

    // Channel count and derived channel index width
    localparam int CHANNELS = 4;
    localparam int CH_W     = 3;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int MODE_W = 3;
    localparam int DUR_W  = 32;
    localparam int TPU_W  = 10;
    localparam int STAT_W = 2;
    localparam int EXP_W  = 4;
    localparam int PROD_W = DUR_W + 1 + TPU_W;

    // Stream and register port widths
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 8;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // Register map
    localparam logic [APB_ADDR_W-1:0] REG_TPU_ADDR = 2'd0;
    localparam logic [TPU_W-1:0]      TPU_RESET    = 10'd60;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CONFIG  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd5;

    // Channel status codes
    localparam logic [STAT_W-1:0] ST_DISABLED = 2'd0;
    localparam logic [STAT_W-1:0] ST_STOPPED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ERROR    = 2'd3;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Classified command as held in the queue
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                ch_ok;
        logic [CH_IDX_W-1:0] ch;
        logic [DUR_W-1:0]    duration;
        logic                one_shot;
        logic [PROD_W-1:0]   prod;      // (duration + 1) * ticks_per_us
    } cmd_t;

    // Queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/mcit_front.sv =====
// Front end: takes input transactions, decodes fields and forms the prescale product.
`timescale 1ns / 1ps
module mcit_front
    import mcit_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [TPU_W-1:0]     tpu,
    input  q_status_t            q_stat,
    output logic                 push,
    output cmd_t                 cmd
);

    logic [CH_W-1:0]  ch_field;
    logic [DUR_W:0]   dur_p1;

    // Field unpacking
    assign ch_field = s_tdata[CH_W-1:0];
    assign dur_p1   = {1'b0, s_tdata[CH_W +: DUR_W]} + {{DUR_W{1'b0}}, 1'b1};

    // Handshake: accept whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // Classification and range product, registered by the queue
    always_comb begin
        cmd.mode     = s_tuser[MODE_W-1:0];
        cmd.ch_ok    = (ch_field < CH_W'(CHANNELS));
        cmd.ch       = ch_field[CH_IDX_W-1:0];
        cmd.duration = s_tdata[CH_W +: DUR_W];
        cmd.one_shot = s_tdata[CH_W + DUR_W];
        cmd.prod     = {{TPU_W{1'b0}}, dur_p1} * {{(DUR_W + 1){1'b0}}, tpu};
    end

endmodule

// ===== rtl/mcit_fifo.sv =====
// Short command queue between the front end and the channel engine.
`timescale 1ns / 1ps
module mcit_fifo
    import mcit_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      cmd_in,
    input  logic      pop,
    output cmd_t      cmd_out,
    output q_status_t q_stat
);

    cmd_t               mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign cmd_out      = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/mcit_back.sv =====
// Channel engine: per-channel state, command execution and the result register.
`timescale 1ns / 1ps
module mcit_back
    import mcit_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_status_t            q_stat,
    input  cmd_t                 cmd,
    output logic                 pop,
    input  logic [TPU_W-1:0]     tpu,
    input  logic                 cfg_wr,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [STAT_W-1:0] stat_reg [CHANNELS];
    logic [STAT_W-1:0] stat_next [CHANNELS];
    logic              os_reg   [CHANNELS];
    logic              os_next  [CHANNELS];
    logic [DUR_W-1:0]  dur_reg  [CHANNELS];
    logic [DUR_W-1:0]  dur_next [CHANNELS];
    logic [DUR_W-1:0]  cnt_reg  [CHANNELS];
    logic [DUR_W-1:0]  cnt_next [CHANNELS];
    logic [DUR_W-1:0]  rl_reg   [CHANNELS];   // ticks_per_us * duration, one lane each

    logic              settle_reg, settle_next;
    logic              out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic              go;
    logic              dur_ok;
    logic [DUR_W-1:0]  load_new;
    logic [DUR_W-1:0]  tpu_ext;
    logic [STAT_W-1:0] res_stat;
    logic [EXP_W-1:0]  res_exp;

    assign tpu_ext  = {{(DUR_W - TPU_W){1'b0}}, tpu};
    assign load_new = cmd.prod[DUR_W-1:0] - tpu_ext - {{(DUR_W - 1){1'b0}}, 1'b1};
    assign dur_ok   = (cmd.duration != '0) && (cmd.prod[PROD_W-1:DUR_W] == '0);

    // Execute one command when the result register frees up; while settle_reg is set
    // after any change of duration or prescale, hold off so the reload lanes catch up
    assign go  = !q_stat.empty && !settle_reg && (!out_valid_reg || m_tready);
    assign pop = go;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            stat_next[i] = stat_reg[i];
            os_next[i]   = os_reg[i];
            dur_next[i]  = dur_reg[i];
            cnt_next[i]  = cnt_reg[i];
        end
        res_stat = ST_ERROR;
        res_exp  = '0;

        if (go) begin
            if (cmd.mode == MODE_TICK) begin
                // Count down every running channel, reload on expiry and stop one-shot channels
                res_stat = ST_DISABLED;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (stat_reg[i] == ST_RUNNING) begin
                        if (cnt_reg[i] == '0) begin
                            if (i < EXP_W) begin
                                res_exp[i % EXP_W] = 1'b1;
                            end
                            cnt_next[i] = rl_reg[i] - {{(DUR_W - 1){1'b0}}, 1'b1};
                            if (os_reg[i]) begin
                                stat_next[i] = ST_STOPPED;
                            end
                        end else begin
                            cnt_next[i] = cnt_reg[i] - {{(DUR_W - 1){1'b0}}, 1'b1};
                        end
                    end
                end
            end else if (cmd.ch_ok) begin
                case (cmd.mode)
                    MODE_CONFIG: begin
                        if (dur_ok) begin
                            os_next[cmd.ch]   = cmd.one_shot;
                            dur_next[cmd.ch]  = cmd.duration;
                            cnt_next[cmd.ch]  = load_new;
                            stat_next[cmd.ch] = ST_STOPPED;
                            res_stat          = ST_STOPPED;
                        end
                    end
                    MODE_START: begin
                        if (stat_reg[cmd.ch] == ST_STOPPED && dur_reg[cmd.ch] != '0) begin
                            stat_next[cmd.ch] = ST_RUNNING;
                            cnt_next[cmd.ch]  = rl_reg[cmd.ch] - {{(DUR_W - 1){1'b0}}, 1'b1};
                            res_stat          = ST_RUNNING;
                        end
                    end
                    MODE_STOP: begin
                        stat_next[cmd.ch] = ST_STOPPED;
                        res_stat          = ST_STOPPED;
                    end
                    MODE_RESTART: begin
                        // Stopped first; a good duration always starts it again
                        stat_next[cmd.ch] = ST_STOPPED;
                        if (dur_ok) begin
                            dur_next[cmd.ch]  = cmd.duration;
                            cnt_next[cmd.ch]  = load_new;
                            stat_next[cmd.ch] = ST_RUNNING;
                            res_stat          = ST_RUNNING;
                        end
                    end
                    MODE_QUERY: begin
                        res_stat = stat_reg[cmd.ch];
                    end
                    default: begin
                        res_stat = ST_ERROR;
                    end
                endcase
            end
        end
    end

    assign settle_next    = cfg_wr ||
                            (go && (cmd.mode == MODE_CONFIG || cmd.mode == MODE_RESTART));
    assign out_valid_next = go ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Control state and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                stat_reg[i] <= ST_DISABLED;
                os_reg[i]   <= 1'b0;
                dur_reg[i]  <= '0;
            end
        end else begin
            settle_reg    <= settle_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < CHANNELS; i++) begin
                stat_reg[i] <= stat_next[i];
                os_reg[i]   <= os_next[i];
                dur_reg[i]  <= dur_next[i];
            end
        end
    end

    // Counters, reload lanes and result payload
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            cnt_reg[i] <= cnt_next[i];
            rl_reg[i]  <= tpu_ext * dur_reg[i];
        end
        if (go) begin
            out_data_reg <= {{(M_TDATA_W - EXP_W - STAT_W){1'b0}}, res_exp, res_stat};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/multi_channel_interval_timer.sv =====
// Top level of the multi-channel interval timer: register port, front end, queue, engine.
//
//  port group | direction | payload
//  -----------+-----------+---------------------------------------------------------
//  s_         | in        | tuser: mode; tdata: channel, duration, one_shot
//  m_         | out       | tdata: status, expired
//  APB        | in/out    | ticks_per_us at byte address 0
//
//  One command per cycle in steady state while the result side accepts; a configure,
//  a restart or a register write then idles the engine while the per-channel reload
//  products settle. From input to result: queue entry, then result register.
//  A two-entry queue lets the input side keep going while the result side stalls.
//  Reset is synchronous, active low: all channels disabled, ticks_per_us = 60.
`timescale 1ns / 1ps
module multi_channel_interval_timer
    import mcit_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [2:0] mode
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [2:0] channel, [34:3] duration, [35] one_shot
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] status, [5:2] expired
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [TPU_W-1:0] tpu_reg;
    logic             cfg_wr;
    logic             push;
    logic             pop;
    cmd_t             cmd_in;
    cmd_t             cmd_out;
    q_status_t        q_stat;

    // Prescale register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_TPU_ADDR);
    assign prdata = {{(APB_DATA_W - TPU_W){1'b0}}, tpu_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg <= TPU_RESET;
        end else if (cfg_wr) begin
            tpu_reg <= pwdata[TPU_W-1:0];
        end
    end

    mcit_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .tpu      (tpu_reg),
        .q_stat   (q_stat),
        .push     (push),
        .cmd      (cmd_in)
    );

    mcit_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (cmd_out),
        .q_stat  (q_stat)
    );

    mcit_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .cmd      (cmd_out),
        .pop      (pop),
        .tpu      (tpu_reg),
        .cfg_wr   (cfg_wr),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/mcit_checker.sv =====
// Port-level checker for the interval timer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcit_port_checker
    import mcit_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata,
    input logic                  pready
);

    logic [M_TDATA_W-1:0] mdata_prev_reg;
    logic [TPU_W-1:0]     wdata_prev_reg;
    logic                 out_stall;
    logic                 out_kept;
    logic                 tick_shape;
    logic                 pad_ok;
    logic                 tpu_write;
    logic                 tpu_match;

    // Copies of the previous cycle's result payload and write data
    always_ff @(posedge aclk) begin
        mdata_prev_reg <= m_tdata;
        wdata_prev_reg <= pwdata[TPU_W-1:0];
    end

    assign out_stall  = m_tvalid && !m_tready;
    assign out_kept   = m_tvalid && (m_tdata == mdata_prev_reg);
    assign tick_shape = (m_tdata[STAT_W-1:0] == ST_DISABLED) || (m_tdata[STAT_W +: EXP_W] == '0);
    assign pad_ok     = (m_tdata[M_TDATA_W-1:STAT_W+EXP_W] == '0);
    assign tpu_write  = psel && penable && pwrite && pready && (paddr == REG_TPU_ADDR);
    assign tpu_match  = (prdata == APB_DATA_W'(wdata_prev_reg));

    // A stalled result holds
    `AST_NEXT(a_out_hold, aclk, aresetn, out_stall, out_kept, "result changed while stalled")

    // Only a tick transaction carries an expiry mask, and ticks report status zero
    `AST_IMPL(a_exp_tick_only, aclk, aresetn, m_tvalid, tick_shape, "expiry on a non-tick result")

    // Padding bits of the result stay clear
    `AST_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, pad_ok, "result padding not zero")

    // A prescale write reads back on the next cycle
    `AST_NEXT(a_tpu_readback, aclk, aresetn, tpu_write, tpu_match, "prescale readback mismatch")

endmodule

bind multi_channel_interval_timer mcit_port_checker u_mcit_checker (.*);
